>>> rtl/dfs_topological_sort_macros.svh
// assertion helpers for the sort block, clocked on clk and quiet in reset
`ifndef DFS_TOPOLOGICAL_SORT_MACROS_SVH
`define DFS_TOPOLOGICAL_SORT_MACROS_SVH

// property that must hold at every edge out of reset
`define DFS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error(msg);

// condition that implies a property in the next cycle
`define DFS_ASSERT_NEXT(label, cond, prop, msg) \
  `DFS_ASSERT(label, (cond) |=> (prop), msg)

`endif

>>> rtl/dfs_pkg.sv
package dfs_pkg;

  localparam int VERTEX_W = 6;
  localparam int COUNT_W  = 7;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_ADD   = 2'd1;
  localparam logic [1:0] CMD_SORT  = 2'd2;

  typedef struct packed {
    logic [VERTEX_W-1:0] src;
    logic [VERTEX_W-1:0] tgt;
  } dfs_edge_t;

  typedef struct packed {
    logic                valid;
    logic                last;
    logic [VERTEX_W-1:0] vertex;
  } dfs_emit_t;

endpackage

>>> rtl/dfs_topological_sort.sv
// depth-first topological sort. a transaction with command add stores one
// directed edge, and clear resets the edge count and the flag; busy stays low and the
// next transaction may follow at once. a sort transaction raises busy, walks
// the graph from vertex 0 upward, then sends the order one vertex per cycle
// on strobe, with last on the final vertex; busy falls at the end of that
// last strobe cycle. the receiver cannot stall, so results must be taken as
// they appear. the edge store has one read port, so the walk compares one
// edge per cycle, save where a hit sends it back to the scan, and makes
// one full pass over the edges per vertex; besides the edge compares the
// walk spends steps on roots, scan entries, stack pops and the emit.
// edges naming a vertex at or above vertex_count, or arriving with the store
// full, are dropped and raise edges_dropped until a clear.
module dfs_topological_sort #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    command,
  input  logic [dfs_pkg::VERTEX_W-1:0]  edge_from,
  input  logic [dfs_pkg::VERTEX_W-1:0]  edge_to,
  input  logic                          cfg_we,
  input  logic [dfs_pkg::COUNT_W-1:0]   cfg_wdata,
  output logic                          strobe,
  output logic [dfs_pkg::VERTEX_W-1:0]  vertex,
  output logic                          last,
  output logic                          edges_dropped
);
  import dfs_pkg::*;

  `include "dfs_topological_sort_macros.svh"

  // edge count holds the capacity itself, the address just the entries
  localparam int EW = $clog2(MAX_EDGES + 1);
  localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;

  logic [COUNT_W-1:0] vertex_count;
  logic [EW-1:0]      edge_total;
  logic               dropped_flag;

  logic [COUNT_W-1:0] n;
  logic               accept;
  logic               add_ok;
  logic               store_we;
  logic               sort_go;
  dfs_edge_t          wr_edge;
  dfs_edge_t          rd_edge;
  logic [AW-1:0]      rd_addr;
  dfs_emit_t          emit;

  // count beyond capacity acts as full capacity
  assign n = (vertex_count > COUNT_W'(MAX_VERTICES)) ? COUNT_W'(MAX_VERTICES)
                                                      : vertex_count;

  assign accept  = start && !busy;
  assign add_ok  = ({1'b0, edge_from} < n) && ({1'b0, edge_to} < n) &&
                   (edge_total < EW'(MAX_EDGES));
  assign store_we = accept && (command == CMD_ADD) && add_ok;
  assign sort_go  = accept && (command == CMD_SORT);
  assign wr_edge.src = edge_from;
  assign wr_edge.tgt = edge_to;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= COUNT_W'(1);
    end else if (cfg_we) begin
      vertex_count <= cfg_wdata;
    end
  end

  // command decode for the clear and add transactions
  always_ff @(posedge clk) begin
    if (rst) begin
      edge_total   <= '0;
      dropped_flag <= 1'b0;
    end else if (accept) begin
      unique case (command)
        CMD_CLEAR: begin
          edge_total   <= '0;
          dropped_flag <= 1'b0;
        end
        CMD_ADD: begin
          if (add_ok) begin
            edge_total <= edge_total + EW'(1);
          end else begin
            dropped_flag <= 1'b1;
          end
        end
        default: begin
          // sort is run by the walker, the unused code does nothing
        end
      endcase
    end
  end

  dfs_edge_store #(
    .MAX_EDGES (MAX_EDGES),
    .AW        (AW)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (edge_total[AW-1:0]),
    .wdata (wr_edge),
    .raddr (rd_addr),
    .rdata (rd_edge)
  );

  dfs_walk #(
    .MAX_VERTICES (MAX_VERTICES),
    .EW           (EW),
    .AW           (AW)
  ) u_walk (
    .clk          (clk),
    .rst          (rst),
    .sort_go      (sort_go),
    .n            (n),
    .edge_total   (edge_total),
    .edge_rd_addr (rd_addr),
    .edge_rd      (rd_edge),
    .busy         (busy),
    .emit         (emit)
  );

  // flag cannot change during a sort, so it rides along directly
  assign strobe        = emit.valid;
  assign vertex        = emit.vertex;
  assign last          = emit.last;
  assign edges_dropped = dropped_flag;

  `DFS_ASSERT(a_strobe_while_busy, strobe |-> busy, "result outside of a sort")
  `DFS_ASSERT(a_last_has_strobe, last |-> strobe, "last without a result")
  `DFS_ASSERT(a_total_in_range, edge_total <= EW'(MAX_EDGES), "edge count past capacity")
  `DFS_ASSERT_NEXT(a_sort_goes_busy, sort_go, busy, "sort did not start")

endmodule

>>> rtl/dfs_edge_store.sv
module dfs_edge_store #(
  parameter int MAX_EDGES = 256,
  parameter int AW        = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  dfs_pkg::dfs_edge_t wdata,
  input  logic [AW-1:0]     raddr,
  output dfs_pkg::dfs_edge_t rdata
);
  import dfs_pkg::*;

  dfs_edge_t mem [MAX_EDGES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/dfs_walk.sv
module dfs_walk #(
  parameter int MAX_VERTICES = 64,
  parameter int EW           = 9,
  parameter int AW           = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         sort_go,
  input  logic [dfs_pkg::COUNT_W-1:0]  n,
  input  logic [EW-1:0]                edge_total,
  output logic [AW-1:0]                edge_rd_addr,
  input  dfs_pkg::dfs_edge_t           edge_rd,
  output logic                         busy,
  output dfs_pkg::dfs_emit_t           emit
);
  import dfs_pkg::*;

  localparam int SW = $clog2(MAX_VERTICES);
  localparam int DW = $clog2(MAX_VERTICES + 1);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_ROOT  = 6'b000010,
    ST_SCAN  = 6'b000100,
    ST_CHECK = 6'b001000,
    ST_POP   = 6'b010000,
    ST_EMIT  = 6'b100000
  } walk_state_t;

  walk_state_t state;
  logic [COUNT_W-1:0]  root;
  logic [VERTEX_W-1:0] cur_u;
  logic [EW-1:0]       cur_p;
  logic [DW-1:0]       depth;
  logic [DW-1:0]       finished;
  logic [MAX_VERTICES-1:0] visited;

  logic [VERTEX_W-1:0] stk_v [MAX_VERTICES];
  logic [EW-1:0]       stk_p [MAX_VERTICES];
  logic [VERTEX_W-1:0] fin_mem [MAX_VERTICES];
  logic [VERTEX_W-1:0] stk_rd_v;
  logic [EW-1:0]       stk_rd_p;
  logic [VERTEX_W-1:0] fin_rd;
  logic                emit_valid;
  logic                emit_last;

  logic [EW-1:0] p_inc;
  logic [EW-1:0] rd_sel;
  logic [DW-1:0] depth_m1;
  logic [DW-1:0] depth_m2;
  logic [DW-1:0] fin_m1;
  logic          hit;
  logic          stk_we;
  logic          fin_we;

  assign p_inc    = cur_p + EW'(1);
  assign rd_sel   = (state == ST_CHECK) ? p_inc : cur_p;
  assign edge_rd_addr = rd_sel[AW-1:0];
  assign depth_m1 = depth - DW'(1);
  assign depth_m2 = depth - DW'(2);
  assign fin_m1   = finished - DW'(1);

  // the one compare unit: does this edge lead to an unvisited vertex
  assign hit = (edge_rd.src == cur_u) && ({1'b0, edge_rd.tgt} < n) &&
               !visited[edge_rd.tgt[SW-1:0]];

  assign stk_we = (state == ST_CHECK) && hit && (depth < DW'(MAX_VERTICES));
  assign fin_we = (state == ST_SCAN) && !(cur_p < edge_total) &&
                  (finished < DW'(MAX_VERTICES));

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_v[depth_m1[SW-1:0]] <= cur_u;
      stk_p[depth_m1[SW-1:0]] <= p_inc;
    end
    stk_rd_v <= stk_v[depth_m2[SW-1:0]];
    stk_rd_p <= stk_p[depth_m2[SW-1:0]];
    if (fin_we) begin
      fin_mem[finished[SW-1:0]] <= cur_u;
    end
    fin_rd <= fin_mem[fin_m1[SW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      root       <= '0;
      depth      <= '0;
      finished   <= '0;
      emit_valid <= 1'b0;
      emit_last  <= 1'b0;
    end else begin
      emit_valid <= 1'b0;
      emit_last  <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (sort_go) begin
            visited  <= '0;
            root     <= '0;
            finished <= '0;
            state    <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          if (root < n) begin
            if (visited[root[SW-1:0]]) begin
              root <= root + COUNT_W'(1);
            end else begin
              visited[root[SW-1:0]] <= 1'b1;
              cur_u <= root[VERTEX_W-1:0];
              cur_p <= '0;
              depth <= DW'(1);
              state <= ST_SCAN;
            end
          end else begin
            state <= ST_EMIT;
          end
        end
        ST_SCAN: begin
          if (cur_p < edge_total) begin
            state <= ST_CHECK;
          end else begin
            if (fin_we) begin
              finished <= finished + DW'(1);
            end
            depth <= depth_m1;
            state <= (depth == DW'(1)) ? ST_ROOT : ST_POP;
          end
        end
        ST_CHECK: begin
          if (hit) begin
            visited[edge_rd.tgt[SW-1:0]] <= 1'b1;
            if (stk_we) begin
              cur_u <= edge_rd.tgt;
              cur_p <= '0;
              depth <= depth + DW'(1);
            end else begin
              cur_p <= p_inc;
            end
            state <= ST_SCAN;
          end else begin
            cur_p <= p_inc;
            state <= (p_inc < edge_total) ? ST_CHECK : ST_SCAN;
          end
        end
        ST_POP: begin
          cur_u <= stk_rd_v;
          cur_p <= stk_rd_p;
          state <= ST_SCAN;
        end
        ST_EMIT: begin
          if (finished != '0) begin
            emit_valid <= 1'b1;
            emit_last  <= (finished == DW'(1));
            finished   <= fin_m1;
          end else begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign busy        = (state != ST_IDLE);
  assign emit.valid  = emit_valid;
  assign emit.last   = emit_last;
  assign emit.vertex = fin_rd;

endmodule

>>> test/dfs_order_checker.sv
`timescale 1ns / 1ps

module dfs_order_checker #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 256
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic                         busy,
  input  logic [1:0]                   command,
  input  logic [dfs_pkg::VERTEX_W-1:0] edge_from,
  input  logic [dfs_pkg::VERTEX_W-1:0] edge_to,
  input  logic                         cfg_we,
  input  logic [dfs_pkg::COUNT_W-1:0]  cfg_wdata,
  input  logic                         strobe,
  input  logic [dfs_pkg::VERTEX_W-1:0] vertex,
  input  logic                         last,
  input  logic                         edges_dropped,
  output int                           fail_count,
  output int                           pending
);

  typedef struct packed {
    logic [dfs_pkg::VERTEX_W-1:0] vertex;
    logic                         last;
    logic                         dropped;
  } order_entry_t;

  logic [dfs_pkg::COUNT_W-1:0]  count_reg;
  logic [dfs_pkg::VERTEX_W-1:0] src_store [MAX_EDGES];
  logic [dfs_pkg::VERTEX_W-1:0] tgt_store [MAX_EDGES];
  int                           edge_cnt;
  logic                         drop_flag;
  order_entry_t                 order_expected [$];
  order_entry_t                 want;
  order_entry_t                 got;
  int                           mismatches;

  function automatic int eff_count();
    return (count_reg > MAX_VERTICES) ? MAX_VERTICES : int'(count_reg);
  endfunction

  function automatic void load_edge(input logic [dfs_pkg::VERTEX_W-1:0] f,
                                    input logic [dfs_pkg::VERTEX_W-1:0] t);
    int n;
    n = eff_count();
    if (int'(f) >= n || int'(t) >= n || edge_cnt >= MAX_EDGES) begin
      drop_flag = 1'b1;
    end else begin
      src_store[edge_cnt] = f;
      tgt_store[edge_cnt] = t;
      edge_cnt++;
    end
  endfunction

  // depth-first walk from vertex 0 upward, queue order in reverse finish order
  function automatic void predict_order();
    int                    n;
    int                    depth;
    int                    top;
    int                    u;
    int                    p;
    int                    t;
    int                    done;
    bit                    descended;
    bit                    hit;
    logic [MAX_VERTICES-1:0] seen;
    int                    stk_v [MAX_VERTICES];
    int                    stk_p [MAX_VERTICES];
    int                    fin [MAX_VERTICES];
    order_entry_t          e;
    n = eff_count();
    done = 0;
    seen = '0;
    for (int root = 0; root < n; root++) begin
      if (!seen[root]) begin
        seen[root] = 1'b1;
        stk_v[0] = root;
        stk_p[0] = 0;
        depth = 1;
        while (depth > 0) begin
          top = depth - 1;
          u = stk_v[top];
          p = stk_p[top];
          descended = 1'b0;
          while (p < edge_cnt && !descended) begin
            t = int'(tgt_store[p]);
            hit = (int'(src_store[p]) == u) && (t < n);
            p++;
            if (hit && !seen[t]) begin
              stk_p[top] = p;
              seen[t] = 1'b1;
              if (depth < MAX_VERTICES) begin
                stk_v[depth] = t;
                stk_p[depth] = 0;
                depth++;
              end
              descended = 1'b1;
            end
          end
          if (!descended) begin
            if (done < MAX_VERTICES) begin
              fin[done] = u;
              done++;
            end
            depth--;
          end
        end
      end
    end
    for (int k = 0; k < done; k++) begin
      e.vertex = dfs_pkg::VERTEX_W'(fin[done-1-k]);
      e.last = (k == done - 1);
      e.dropped = drop_flag;
      order_expected.insert(order_expected.size(), e);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      count_reg = dfs_pkg::COUNT_W'(1);
      edge_cnt = 0;
      drop_flag = 1'b0;
      mismatches = 0;
      order_expected.delete();
      fail_count <= 0;
      pending <= 0;
    end else begin
      if (cfg_we) begin
        count_reg = cfg_wdata;
      end
      if (start && !busy) begin
        case (command)
          dfs_pkg::CMD_CLEAR: begin
            edge_cnt = 0;
            drop_flag = 1'b0;
          end
          dfs_pkg::CMD_ADD:  load_edge(edge_from, edge_to);
          dfs_pkg::CMD_SORT: predict_order();
          default: ;
        endcase
      end
      if (strobe) begin
        got = '{vertex: vertex, last: last, dropped: edges_dropped};
        if (order_expected.size() == 0) begin
          $display("%0t: unexpected vertex %0d last %0b dropped %0b", $time,
                   vertex, last, edges_dropped);
          mismatches++;
        end else begin
          want = order_expected.pop_front();
          if (got !== want) begin
            $display("%0t: expected vertex %0d last %0b dropped %0b, got vertex %0d last %0b dropped %0b",
                     $time, want.vertex, want.last, want.dropped,
                     got.vertex, got.last, got.dropped);
            mismatches++;
          end
        end
      end
      fail_count <= mismatches;
      pending <= order_expected.size();
    end
  end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int MAX_VERTICES = 64;
  localparam int MAX_EDGES    = 256;
  // command code the block leaves unused
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  // quiet cycles after the last vertex, to catch stray strobes
  localparam int SETTLE_CYCLES = 40;
  // a run made only of the longest sorts the stimulus can build still ends
  // well inside this limit
  localparam int LIMIT_NS = 50_000_000;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         start = 1'b0;
  logic                         busy;
  logic [1:0]                   command = dfs_pkg::CMD_CLEAR;
  logic [dfs_pkg::VERTEX_W-1:0] edge_from = '0;
  logic [dfs_pkg::VERTEX_W-1:0] edge_to = '0;
  logic                         cfg_we = 1'b0;
  logic [dfs_pkg::COUNT_W-1:0]  cfg_wdata = '0;
  logic                         strobe;
  logic [dfs_pkg::VERTEX_W-1:0] vertex;
  logic                         last;
  logic                         edges_dropped;

  int fail_count;
  int pending;
  int sender_idle_pct = 0;   // chance in a hundred of a gap before a transaction
  int cur_count = 1;         // vertex_count as last written
  int adds_since_clear = 0;  // bounds the store, and so the sort time
  int items_sent = 0;        // transactions the block acts on
  int goal;

  always #4 clk = ~clk;

  dfs_topological_sort #(
    .MAX_VERTICES(MAX_VERTICES),
    .MAX_EDGES   (MAX_EDGES)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .command      (command),
    .edge_from    (edge_from),
    .edge_to      (edge_to),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .strobe       (strobe),
    .vertex       (vertex),
    .last         (last),
    .edges_dropped(edges_dropped)
  );

  dfs_order_checker #(
    .MAX_VERTICES(MAX_VERTICES),
    .MAX_EDGES   (MAX_EDGES)
  ) u_checker (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .command      (command),
    .edge_from    (edge_from),
    .edge_to      (edge_to),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .strobe       (strobe),
    .vertex       (vertex),
    .last         (last),
    .edges_dropped(edges_dropped),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  // hard stop in case the block hangs
  initial begin
    #(LIMIT_NS);
    $display("FAIL");
    $finish;
  end

  // any 6-bit value
  function automatic logic [dfs_pkg::VERTEX_W-1:0] any_vertex();
    return dfs_pkg::VERTEX_W'($urandom_range(63));
  endfunction

  // mostly a vertex inside the graph, now and then any 6-bit value
  function automatic logic [dfs_pkg::VERTEX_W-1:0] pick_vertex();
    int n;
    n = (cur_count > MAX_VERTICES) ? MAX_VERTICES : cur_count;
    if (n == 0 || $urandom_range(9) == 0) begin
      return any_vertex();
    end
    return dfs_pkg::VERTEX_W'($urandom_range(n - 1));
  endfunction

  // one transaction; called right after an accepting edge or from idle.
  // start stays high into the next transaction unless a gap is drawn,
  // so it never gets two assignments in one step
  task automatic send_item(input logic [1:0] cmd,
                           input logic [dfs_pkg::VERTEX_W-1:0] f,
                           input logic [dfs_pkg::VERTEX_W-1:0] t);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    command <= cmd;
    edge_from <= f;
    edge_to <= t;
    // accepted at the first rising edge that sees busy low
    do @(posedge clk); while (busy);
    if (cmd == dfs_pkg::CMD_CLEAR) begin
      adds_since_clear = 0;
    end else if (cmd == dfs_pkg::CMD_ADD) begin
      adds_since_clear++;
    end
    if (cmd != CMD_UNUSED) begin
      items_sent++;
    end
  endtask

  // sender holds off until every expected vertex is out and busy has fallen;
  // busy also covers a sort that emits nothing
  task automatic wait_idle();
    @(negedge clk);
    start <= 1'b0;
    do @(posedge clk); while (pending != 0 || busy);
    repeat (2) @(posedge clk);
  endtask

  // vertex_count is only ever written while the block is idle
  task automatic write_count(input logic [dfs_pkg::COUNT_W-1:0] v);
    wait_idle();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_count = int'(v);
  endtask

  // one random graph: maybe a new count, maybe a clear, a few edges with
  // some noise mixed in, then a sort, sometimes a second one straight after
  task automatic random_set();
    int r;
    r = $urandom_range(9);
    if ($urandom_range(2) != 0) begin
      if (r == 0) begin
        write_count(7'd0);
      end else if (r == 1) begin
        write_count(dfs_pkg::COUNT_W'($urandom_range(127, 64)));
      end else if (r == 2) begin
        write_count(7'd1);
      end else begin
        write_count(dfs_pkg::COUNT_W'($urandom_range(16, 2)));
      end
    end
    if (adds_since_clear > 40 || $urandom_range(4) != 0) begin
      send_item(dfs_pkg::CMD_CLEAR, any_vertex(), any_vertex());
    end
    repeat ($urandom_range(12)) begin
      r = $urandom_range(99);
      if (r < 5) begin
        send_item(CMD_UNUSED, any_vertex(), any_vertex());
      end else if (r < 8) begin
        send_item(dfs_pkg::CMD_CLEAR, any_vertex(), any_vertex());
      end else begin
        send_item(dfs_pkg::CMD_ADD, pick_vertex(), pick_vertex());
      end
    end
    send_item(dfs_pkg::CMD_SORT, any_vertex(), any_vertex());
    if ($urandom_range(3) == 0) begin
      // queued behind a running sort, start held high through busy
      send_item(dfs_pkg::CMD_SORT, any_vertex(), any_vertex());
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: reset count of one gives a single vertex
    send_item(dfs_pkg::CMD_SORT, 6'd0, 6'd0);
    // edge outside a one-vertex graph is dropped and flagged
    send_item(dfs_pkg::CMD_ADD, 6'd0, 6'd1);
    send_item(dfs_pkg::CMD_SORT, 6'd63, 6'd63);
    send_item(dfs_pkg::CMD_CLEAR, 6'd63, 6'd0);

    // empty graph: adds all dropped, sort gives nothing
    write_count(7'd0);
    send_item(dfs_pkg::CMD_ADD, 6'd0, 6'd0);
    send_item(dfs_pkg::CMD_SORT, 6'd0, 6'd63);

    // count above the limit is clamped to 64 vertices; self loop, top corners
    write_count(7'd127);
    send_item(dfs_pkg::CMD_CLEAR, 6'd0, 6'd0);
    send_item(dfs_pkg::CMD_ADD, 6'd63, 6'd0);
    send_item(dfs_pkg::CMD_ADD, 6'd0, 6'd63);
    send_item(dfs_pkg::CMD_ADD, 6'd63, 6'd63);
    send_item(dfs_pkg::CMD_ADD, 6'd62, 6'd63);
    send_item(dfs_pkg::CMD_SORT, 6'd0, 6'd0);
    send_item(CMD_UNUSED, 6'd63, 6'd63);

    // small graph with a cycle, then the count lowered under loaded edges
    write_count(7'd8);
    send_item(dfs_pkg::CMD_CLEAR, 6'd0, 6'd0);
    send_item(dfs_pkg::CMD_ADD, 6'd1, 6'd2);
    send_item(dfs_pkg::CMD_ADD, 6'd2, 6'd3);
    send_item(dfs_pkg::CMD_ADD, 6'd0, 6'd3);
    send_item(dfs_pkg::CMD_ADD, 6'd3, 6'd1);
    send_item(dfs_pkg::CMD_ADD, 6'd5, 6'd7);
    send_item(dfs_pkg::CMD_ADD, 6'd7, 6'd6);
    send_item(dfs_pkg::CMD_SORT, 6'd0, 6'd0);
    write_count(7'd4);
    send_item(dfs_pkg::CMD_SORT, 6'd0, 6'd0);
    send_item(dfs_pkg::CMD_ADD, 6'd63, 6'd63);
    send_item(dfs_pkg::CMD_SORT, 6'd0, 6'd0);
    // clear drops the flag again
    send_item(dfs_pkg::CMD_CLEAR, 6'd0, 6'd0);
    send_item(dfs_pkg::CMD_SORT, 6'd0, 6'd0);

    // fill the edge store past capacity, then one full-size sort
    write_count(7'd64);
    sender_idle_pct = 10;
    send_item(dfs_pkg::CMD_CLEAR, 6'd0, 6'd0);
    repeat (MAX_EDGES + 2) begin
      send_item(dfs_pkg::CMD_ADD, any_vertex(), any_vertex());
    end
    send_item(dfs_pkg::CMD_SORT, 6'd0, 6'd0);

    // random graphs under three sender profiles: gappy, very gappy, back to back
    items_sent = 0;
    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct = (phase == 0) ? 36 : (phase == 1) ? 77 : 0;
      goal = items_sent + 55;
      while (items_sent < goal) begin
        random_set();
      end
      // hold off once per profile until the last vertex is out
      wait_idle();
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/dfs_pkg.sv
rtl/dfs_edge_store.sv
rtl/dfs_walk.sv
rtl/dfs_topological_sort.sv
test/dfs_order_checker.sv
test/tb_top.sv
